### rtl/hpq_pkg.sv
package hpq_pkg;

  // Default heap depth
  localparam int unsigned DEPTH_DEF = 64;

  // Field widths
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned CAP_W    = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_INC = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SMALLER   = 3'd4;

  // Program step addresses
  localparam int unsigned PC_W = 5;
  localparam logic [PC_W-1:0] S_DISP  = 5'd0;
  localparam logic [PC_W-1:0] S_ENQ0  = 5'd1;
  localparam logic [PC_W-1:0] S_ENQ1  = 5'd2;
  localparam logic [PC_W-1:0] S_FULL  = 5'd3;
  localparam logic [PC_W-1:0] S_INC0  = 5'd4;
  localparam logic [PC_W-1:0] S_INC1  = 5'd5;
  localparam logic [PC_W-1:0] S_UP0   = 5'd6;
  localparam logic [PC_W-1:0] S_UP1   = 5'd7;
  localparam logic [PC_W-1:0] S_UPW   = 5'd8;
  localparam logic [PC_W-1:0] S_DEQ0  = 5'd9;
  localparam logic [PC_W-1:0] S_DEQ1  = 5'd10;
  localparam logic [PC_W-1:0] S_DN0   = 5'd11;
  localparam logic [PC_W-1:0] S_DN1   = 5'd12;
  localparam logic [PC_W-1:0] S_DNW   = 5'd13;
  localparam logic [PC_W-1:0] S_EMPTY = 5'd14;
  localparam logic [PC_W-1:0] S_BAD   = 5'd15;
  localparam logic [PC_W-1:0] S_SMALL = 5'd16;
  localparam logic [PC_W-1:0] S_FIN   = 5'd17;

  // Control word fields
  typedef enum logic [2:0] {
    J_NEXT, J_GOTO, J_IF, J_HOLD, J_DISPATCH
  } jmp_e;

  typedef enum logic [3:0] {
    C_NONE, C_FULL, C_HOLE_ZERO, C_K_GT_A, C_EMPTY, C_NO_LEFT,
    C_BIG_MOVES, C_POS_BAD, C_A_GT_K, C_OUT_FREE
  } cond_e;

  typedef enum logic [2:0] {
    R_NONE, R_PARENT, R_KIDS, R_ROOT_LAST, R_POS
  } rd_e;

  typedef enum logic [1:0] {
    W_NONE, W_MOVE_UP, W_MOVE_DOWN, W_KEY
  } wr_e;

  typedef enum logic [3:0] {
    A_NONE, A_ACCEPT, A_ENQ_SETUP, A_CNT_INC, A_SET_FULL, A_DEQ_LOAD,
    A_SET_EMPTY, A_INC_SETUP, A_SET_BAD, A_SET_SMALL, A_EMIT
  } act_e;

  typedef struct packed {
    jmp_e            jmp;
    cond_e           cond;
    logic [PC_W-1:0] target;
    rd_e             rd;
    wr_e             wr;
    logic            wr_on_cond;
    act_e            act;
  } ctrl_t;

  function automatic ctrl_t cw(jmp_e j, cond_e c, logic [PC_W-1:0] t, rd_e r, wr_e w,
                               logic won, act_e a);
    ctrl_t word;
    word.jmp        = j;
    word.cond       = c;
    word.target     = t;
    word.rd         = r;
    word.wr         = w;
    word.wr_on_cond = won;
    word.act        = a;
    return word;
  endfunction

  // Microprogram
  function automatic ctrl_t rom_word(logic [PC_W-1:0] pc);
    ctrl_t word;
    unique case (pc)
      S_DISP:  word = cw(J_DISPATCH, C_NONE, S_DISP, R_NONE, W_NONE, 1'b0, A_ACCEPT);
      S_ENQ0:  word = cw(J_IF, C_FULL, S_FULL, R_NONE, W_NONE, 1'b0, A_ENQ_SETUP);
      S_ENQ1:  word = cw(J_GOTO, C_NONE, S_UP0, R_NONE, W_NONE, 1'b0, A_CNT_INC);
      S_FULL:  word = cw(J_GOTO, C_NONE, S_FIN, R_NONE, W_NONE, 1'b0, A_SET_FULL);
      S_INC0:  word = cw(J_IF, C_POS_BAD, S_BAD, R_POS, W_NONE, 1'b0, A_INC_SETUP);
      S_INC1:  word = cw(J_IF, C_A_GT_K, S_SMALL, R_NONE, W_NONE, 1'b0, A_NONE);
      S_UP0:   word = cw(J_IF, C_HOLE_ZERO, S_UPW, R_PARENT, W_NONE, 1'b0, A_NONE);
      S_UP1:   word = cw(J_IF, C_K_GT_A, S_UP0, R_NONE, W_MOVE_UP, 1'b1, A_NONE);
      S_UPW:   word = cw(J_GOTO, C_NONE, S_FIN, R_NONE, W_KEY, 1'b0, A_NONE);
      S_DEQ0:  word = cw(J_IF, C_EMPTY, S_EMPTY, R_ROOT_LAST, W_NONE, 1'b0, A_NONE);
      S_DEQ1:  word = cw(J_NEXT, C_NONE, S_DISP, R_NONE, W_NONE, 1'b0, A_DEQ_LOAD);
      S_DN0:   word = cw(J_IF, C_NO_LEFT, S_DNW, R_KIDS, W_NONE, 1'b0, A_NONE);
      S_DN1:   word = cw(J_IF, C_BIG_MOVES, S_DN0, R_NONE, W_MOVE_DOWN, 1'b1, A_NONE);
      S_DNW:   word = cw(J_GOTO, C_NONE, S_FIN, R_NONE, W_KEY, 1'b0, A_NONE);
      S_EMPTY: word = cw(J_GOTO, C_NONE, S_FIN, R_NONE, W_NONE, 1'b0, A_SET_EMPTY);
      S_BAD:   word = cw(J_GOTO, C_NONE, S_FIN, R_NONE, W_NONE, 1'b0, A_SET_BAD);
      S_SMALL: word = cw(J_GOTO, C_NONE, S_FIN, R_NONE, W_NONE, 1'b0, A_SET_SMALL);
      S_FIN:   word = cw(J_HOLD, C_OUT_FREE, S_DISP, R_NONE, W_NONE, 1'b0, A_EMIT);
      default: word = cw(J_GOTO, C_NONE, S_DISP, R_NONE, W_NONE, 1'b0, A_NONE);
    endcase
    return word;
  endfunction

  // Entry step for each opcode; the unused opcode goes straight to the result
  function automatic logic [PC_W-1:0] dispatch_target(logic [OP_W-1:0] op);
    logic [PC_W-1:0] t;
    unique case (op)
      OP_ENQ:  t = S_ENQ0;
      OP_DEQ:  t = S_DEQ0;
      OP_INC:  t = S_INC0;
      default: t = S_FIN;
    endcase
    return t;
  endfunction

endpackage

### rtl/hpq_seq.sv
module hpq_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [hpq_pkg::OP_W-1:0]  opcode_i,
  input  logic                      cond_i,
  output logic                      in_ready_o,
  output hpq_pkg::ctrl_t            ctrl_o
);

  logic [hpq_pkg::PC_W-1:0] pc_d, pc_q;

  // Fetch the control word for the current step
  assign ctrl_o     = hpq_pkg::rom_word(pc_q);
  assign in_ready_o = (pc_q == hpq_pkg::S_DISP);

  // Select the next step
  always_comb begin
    unique case (ctrl_o.jmp)
      hpq_pkg::J_NEXT:     pc_d = pc_q + 1'b1;
      hpq_pkg::J_GOTO:     pc_d = ctrl_o.target;
      hpq_pkg::J_IF:       pc_d = cond_i ? ctrl_o.target : pc_q + 1'b1;
      hpq_pkg::J_HOLD:     pc_d = cond_i ? ctrl_o.target : pc_q;
      hpq_pkg::J_DISPATCH: pc_d = in_valid_i ? hpq_pkg::dispatch_target(opcode_i) : pc_q;
      default:             pc_d = hpq_pkg::S_DISP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= hpq_pkg::S_DISP;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### rtl/hpq_dp.sv
module hpq_dp #(
  parameter int unsigned DEPTH = hpq_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hpq_pkg::ctrl_t                ctrl_i,
  output logic                          cond_o,
  input  logic                          in_fire_i,
  input  logic [hpq_pkg::KEY_W-1:0]     key_i,
  input  logic [hpq_pkg::POS_W-1:0]     pos_i,
  input  logic                          cfg_valid_i,
  input  logic [hpq_pkg::CAP_W-1:0]     cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hpq_pkg::KEY_W-1:0]     max_key_o,
  output logic [hpq_pkg::STATUS_W-1:0]  status_o,
  output logic [hpq_pkg::COUNT_W-1:0]   count_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = ((AW + 3) > 8) ? (AW + 3) : 8;

  logic [hpq_pkg::KEY_W-1:0] mem [DEPTH];

  logic [CW-1:0]                 cnt_d, cnt_q;
  logic [hpq_pkg::CAP_W-1:0]     cap_q;
  logic                          out_valid_q;
  logic [AW-1:0]                 hole_q;
  logic [hpq_pkg::KEY_W-1:0]     k_q, max_q, rd_a_q, rd_b_q;
  logic [hpq_pkg::POS_W-1:0]     pos_q;
  logic [hpq_pkg::STATUS_W-1:0]  status_q;
  logic [hpq_pkg::KEY_W-1:0]     out_key_q;
  logic [hpq_pkg::STATUS_W-1:0]  out_status_q;
  logic [hpq_pkg::COUNT_W-1:0]   out_count_q;

  logic [AW-1:0]                 parent, addr_a, addr_b, big_idx;
  logic [AW+1:0]                 kid_l, kid_r;
  logic [CW-1:0]                 cnt_m1;
  logic [CMPW-1:0]               cnt_w;
  logic                          full, left_ok, right_ok, sel_l, sel_r, big_moves;
  logic [hpq_pkg::KEY_W-1:0]     v_l, big_val, wr_data;
  logic                          wr_en, out_free, emit;

  // Tree neighbors of the hole
  assign parent = (hole_q - 1'b1) >> 1;
  assign kid_l  = {1'b0, hole_q, 1'b1};
  assign kid_r  = kid_l + 1'b1;
  assign cnt_m1 = cnt_q - 1'b1;
  assign cnt_w  = CMPW'(cnt_q);

  assign full     = (cnt_w >= CMPW'(cap_q)) || (cnt_w >= CMPW'(DEPTH));
  assign left_ok  = CMPW'(kid_l) < cnt_w;
  assign right_ok = CMPW'(kid_r) < cnt_w;

  // Pick the larger child that beats the moving key; left wins ties
  assign sel_l     = left_ok && ($signed(rd_a_q) > $signed(k_q));
  assign v_l       = sel_l ? rd_a_q : k_q;
  assign sel_r     = right_ok && ($signed(rd_b_q) > $signed(v_l));
  assign big_moves = sel_l || sel_r;
  assign big_idx   = sel_r ? kid_r[AW-1:0] : kid_l[AW-1:0];
  assign big_val   = sel_r ? rd_b_q : rd_a_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = (ctrl_i.act == hpq_pkg::A_EMIT) && out_free;

  // Evaluate the jump condition
  always_comb begin
    unique case (ctrl_i.cond)
      hpq_pkg::C_NONE:      cond_o = 1'b0;
      hpq_pkg::C_FULL:      cond_o = full;
      hpq_pkg::C_HOLE_ZERO: cond_o = (hole_q == '0);
      hpq_pkg::C_K_GT_A:    cond_o = $signed(k_q) > $signed(rd_a_q);
      hpq_pkg::C_EMPTY:     cond_o = (cnt_q == '0);
      hpq_pkg::C_NO_LEFT:   cond_o = !left_ok;
      hpq_pkg::C_BIG_MOVES: cond_o = big_moves;
      hpq_pkg::C_POS_BAD:   cond_o = CMPW'(pos_q) >= cnt_w;
      hpq_pkg::C_A_GT_K:    cond_o = $signed(rd_a_q) > $signed(k_q);
      hpq_pkg::C_OUT_FREE:  cond_o = out_free;
      default:              cond_o = 1'b0;
    endcase
  end

  // Read addresses
  always_comb begin
    unique case (ctrl_i.rd)
      hpq_pkg::R_PARENT: begin
        addr_a = parent;
        addr_b = '0;
      end
      hpq_pkg::R_KIDS: begin
        addr_a = kid_l[AW-1:0];
        addr_b = kid_r[AW-1:0];
      end
      hpq_pkg::R_ROOT_LAST: begin
        addr_a = '0;
        addr_b = cnt_m1[AW-1:0];
      end
      hpq_pkg::R_POS: begin
        addr_a = AW'(pos_q);
        addr_b = '0;
      end
      default: begin
        addr_a = '0;
        addr_b = '0;
      end
    endcase
  end

  // Write port
  always_comb begin
    wr_en = (ctrl_i.wr != hpq_pkg::W_NONE) && (!ctrl_i.wr_on_cond || cond_o);
    unique case (ctrl_i.wr)
      hpq_pkg::W_MOVE_UP:   wr_data = rd_a_q;
      hpq_pkg::W_MOVE_DOWN: wr_data = big_val;
      hpq_pkg::W_KEY:       wr_data = k_q;
      default:              wr_data = k_q;
    endcase
  end

  // Count update
  always_comb begin
    unique case (ctrl_i.act)
      hpq_pkg::A_CNT_INC:  cnt_d = cnt_q + 1'b1;
      hpq_pkg::A_DEQ_LOAD: cnt_d = cnt_m1;
      default:             cnt_d = cnt_q;
    endcase
  end

  // Heap store with registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[hole_q] <= wr_data;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  // Control state: count, capacity, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cap_q       <= hpq_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr == hpq_pkg::W_MOVE_UP && wr_en) begin
      hole_q <= parent;
    end else if (ctrl_i.wr == hpq_pkg::W_MOVE_DOWN && wr_en) begin
      hole_q <= big_idx;
    end
    unique case (ctrl_i.act)
      hpq_pkg::A_ACCEPT: begin
        if (in_fire_i) begin
          k_q      <= key_i;
          pos_q    <= pos_i;
          max_q    <= '0;
          status_q <= hpq_pkg::ST_OK;
        end
      end
      hpq_pkg::A_ENQ_SETUP: hole_q   <= cnt_q[AW-1:0];
      hpq_pkg::A_INC_SETUP: hole_q   <= AW'(pos_q);
      hpq_pkg::A_SET_FULL:  status_q <= hpq_pkg::ST_FULL;
      hpq_pkg::A_SET_EMPTY: status_q <= hpq_pkg::ST_EMPTY;
      hpq_pkg::A_SET_BAD:   status_q <= hpq_pkg::ST_BAD_INDEX;
      hpq_pkg::A_SET_SMALL: status_q <= hpq_pkg::ST_SMALLER;
      hpq_pkg::A_DEQ_LOAD: begin
        max_q  <= rd_a_q;
        k_q    <= rd_b_q;
        hole_q <= '0;
      end
      default: ;
    endcase
    if (emit) begin
      out_key_q    <= max_q;
      out_status_q <= status_q;
      out_count_q  <= hpq_pkg::COUNT_W'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign max_key_o   = out_key_q;
  assign status_o    = out_status_q;
  assign count_o     = out_count_q;

endmodule

### rtl/binary_max_heap_priority_queue.sv
// Channel   Direction  Signals                          Payload
// s_axis    in         tvalid/tready/tdata/tuser        key, position; opcode in tuser
// m_axis    out        tvalid/tready/tdata              max_key, status, entry_count
// cfg       in         cfg_valid_i/cfg_ready_o/data     capacity
//
// Operations: a sift moves L levels (at most log2(DEPTH)); each level costs one
// registered store read and one compare-and-move step of the microprogram. Refused
// items are reported without a sift; a smaller new key is refused after one extra
// store read, and the unused opcode goes straight to the result.
// Reset: count clears and capacity returns to 64; the heap store is not cleared.
// Stalls: a finished result waits in the output register; the sequencer holds at
// its last step until the result can be loaded. s_axis_tready is high only while
// the sequencer sits at dispatch. Capacity writes are taken in every cycle.
module binary_max_heap_priority_queue #(
  parameter int unsigned DEPTH = hpq_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // key_value[31:0], position[37:32], zero pad
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // max_key[31:0], status[34:32], entry_count[41:35]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  hpq_pkg::ctrl_t                ctrl;
  logic                          cond;
  logic                          in_fire;
  logic [hpq_pkg::KEY_W-1:0]     max_key;
  logic [hpq_pkg::STATUS_W-1:0]  status;
  logic [hpq_pkg::COUNT_W-1:0]   entry_count;

  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // Microprogram sequencer
  hpq_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .cond_i     (cond),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl)
  );

  // Heap datapath and store
  hpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cond_o      (cond),
    .in_fire_i   (in_fire),
    .key_i       (s_axis_tdata[31:0]),
    .pos_i       (s_axis_tdata[37:32]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .max_key_o   (max_key),
    .status_o    (status),
    .count_o     (entry_count)
  );

  assign m_axis_tdata = {6'b0, entry_count, status, max_key};

endmodule
